[sv/pidsq_pkg.sv]
// Shared types and constants for the PID core with a square-wave setpoint.
// Holds field widths, register indexes and register reset values.
// No dependencies.
package pidsq_pkg;

  localparam int unsigned DistW  = 13;
  localparam int unsigned PhaseW = 16;
  localparam int unsigned GainW  = 24;
  localparam int unsigned ErrW   = 14;
  localparam int unsigned PrevW  = 15;
  localparam int unsigned SumW   = 32;
  localparam int unsigned DriveW = 32;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned IdxW   = 3;

  // Q8.16 gains: the fraction is dropped by the final rounding shift.
  localparam int unsigned FracW  = 16;
  localparam int unsigned ProdPW = GainW + 1 + ErrW;
  localparam int unsigned ProdIW = GainW + 1 + SumW;
  localparam int unsigned ProdDW = GainW + 1 + PrevW;
  localparam int unsigned AccW   = ProdIW + 2;

  typedef logic [DistW-1:0]  dist_t;
  typedef logic [PhaseW-1:0] phase_t;
  typedef logic [GainW-1:0]  gain_t;

  localparam logic [IdxW-1:0] RegTargetA    = 3'd0;
  localparam logic [IdxW-1:0] RegTargetB    = 3'd1;
  localparam logic [IdxW-1:0] RegCycleLen   = 3'd2;
  localparam logic [IdxW-1:0] RegGainP      = 3'd3;
  localparam logic [IdxW-1:0] RegGainI      = 3'd4;
  localparam logic [IdxW-1:0] RegGainD      = 3'd5;

  localparam dist_t  TargetAReset  = 13'd150;
  localparam dist_t  TargetBReset  = 13'd200;
  localparam phase_t CycleLenReset = 16'd500;
  localparam gain_t  GainPReset    = 24'd655360;
  localparam gain_t  GainIReset    = 24'd140;
  localparam gain_t  GainDReset    = 24'd1536000;

endpackage

[sv/pid_with_square_setpoint_core.sv]
// Top level of the PID core with a square-wave setpoint.
// Uses pidsq_pkg for widths, register indexes and reset values.
//
// One distance word in, one drive word out. An accepted word passes through the
// stage-1, stage-2 and output registers before its result is valid, and one
// new word is accepted every cycle while the output is not stalled. The first
// stage advances the phase counter, picks the setpoint and updates the error
// history and the saturating error sum; the second forms the three gain
// products; the third adds them, rounds half up to an integer and clamps to 32
// bits. A stall at the output holds the whole pipeline.
// Registers sit at byte addresses 4*i (target_a, target_b, cycle_length,
// gain_p, gain_i, gain_d); write them only while no word is in flight.
module pid_with_square_setpoint_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [pidsq_pkg::AddrW-1:0]           paddr,
  input  logic [pidsq_pkg::DataW-1:0]           pwdata,
  output logic [pidsq_pkg::DataW-1:0]           prdata,
  output logic                                  pready,
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  logic [pidsq_pkg::DistW-1:0]           distance_sample,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [pidsq_pkg::DriveW-1:0]   drive,
  output logic [pidsq_pkg::DistW-1:0]           setpoint_used,
  output logic                                  integ_saturated
);
  import pidsq_pkg::*;

  // Configuration registers.
  dist_t  target_a, target_b;
  phase_t cycle_length;
  gain_t  gain_p, gain_i, gain_d;

  logic            cfg_write;
  logic [IdxW-1:0] cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = paddr[AddrW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      target_a     <= TargetAReset;
      target_b     <= TargetBReset;
      cycle_length <= CycleLenReset;
      gain_p       <= GainPReset;
      gain_i       <= GainIReset;
      gain_d       <= GainDReset;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        RegTargetA:  target_a     <= pwdata[DistW-1:0];
        RegTargetB:  target_b     <= pwdata[DistW-1:0];
        RegCycleLen: cycle_length <= pwdata[PhaseW-1:0];
        RegGainP:    gain_p       <= pwdata[GainW-1:0];
        RegGainI:    gain_i       <= pwdata[GainW-1:0];
        RegGainD:    gain_d       <= pwdata[GainW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegTargetA:  prdata = {{(DataW-DistW){1'b0}}, target_a};
      RegTargetB:  prdata = {{(DataW-DistW){1'b0}}, target_b};
      RegCycleLen: prdata = {{(DataW-PhaseW){1'b0}}, cycle_length};
      RegGainP:    prdata = {{(DataW-GainW){1'b0}}, gain_p};
      RegGainI:    prdata = {{(DataW-GainW){1'b0}}, gain_i};
      RegGainD:    prdata = {{(DataW-GainW){1'b0}}, gain_d};
      default:     prdata = '0;
    endcase
  end

  // The whole pipeline moves together unless the output word is held.
  logic advance, accept;
  assign advance      = !result_valid || !result_stall;
  assign sample_stall = !advance;
  assign accept       = sample_valid && advance;

  // Stage 1: phase, setpoint, error and the running sum.
  phase_t                    phase_count;
  logic signed [PrevW-1:0]   previous_error;
  logic signed [SumW-1:0]    error_sum;

  logic [PhaseW:0]           phase_inc;
  phase_t                    phase_count_next;
  dist_t                     setpoint;
  logic signed [ErrW-1:0]    err;
  logic signed [PrevW-1:0]   diff;
  logic signed [SumW:0]      sum_wide;
  logic signed [SumW-1:0]    error_sum_next;
  logic                      sum_clip;

  always_comb begin
    phase_inc        = {1'b0, phase_count} + {{PhaseW{1'b0}}, 1'b1};
    phase_count_next = (phase_inc >= {1'b0, cycle_length}) ? '0
                                                           : phase_inc[PhaseW-1:0];
    setpoint = (phase_count_next < (cycle_length >> 1)) ? target_a : target_b;
    err      = $signed({1'b0, distance_sample}) - $signed({1'b0, setpoint});
    diff     = $signed({err[ErrW-1], err}) - previous_error;
    sum_wide = $signed({error_sum[SumW-1], error_sum})
             + $signed({{(SumW+1-ErrW){err[ErrW-1]}}, err});
    // The sum clips when the two top bits of the wide sum disagree.
    sum_clip = sum_wide[SumW] != sum_wide[SumW-1];
    if (!sum_clip) begin
      error_sum_next = sum_wide[SumW-1:0];
    end else if (sum_wide[SumW]) begin
      error_sum_next = {1'b1, {(SumW-1){1'b0}}};
    end else begin
      error_sum_next = {1'b0, {(SumW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count    <= '0;
      previous_error <= '0;
      error_sum      <= '0;
    end else if (accept) begin
      phase_count    <= phase_count_next;
      previous_error <= {err[ErrW-1], err};
      error_sum      <= error_sum_next;
    end
  end

  logic                    s1_valid;
  logic signed [ErrW-1:0]  s1_err;
  logic signed [PrevW-1:0] s1_diff;
  logic signed [SumW-1:0]  s1_sum;
  dist_t                   s1_setpoint;
  logic                    s1_clip;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_err      <= err;
      s1_diff     <= diff;
      s1_sum      <= error_sum_next;
      s1_setpoint <= setpoint;
      s1_clip     <= sum_clip;
    end
  end

  // Stage 2: the three gain products. Gains are unsigned, so they are
  // zero-extended before the signed multiply.
  logic                      s2_valid;
  logic signed [ProdPW-1:0]  s2_prod_p;
  logic signed [ProdIW-1:0]  s2_prod_i;
  logic signed [ProdDW-1:0]  s2_prod_d;
  dist_t                     s2_setpoint;
  logic                      s2_clip;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_prod_p   <= $signed({{(ProdPW-GainW){1'b0}}, gain_p})
                   * $signed({{(ProdPW-ErrW){s1_err[ErrW-1]}}, s1_err});
      s2_prod_i   <= $signed({{(ProdIW-GainW){1'b0}}, gain_i})
                   * $signed({{(ProdIW-SumW){s1_sum[SumW-1]}}, s1_sum});
      s2_prod_d   <= $signed({{(ProdDW-GainW){1'b0}}, gain_d})
                   * $signed({{(ProdDW-PrevW){s1_diff[PrevW-1]}}, s1_diff});
      s2_setpoint <= s1_setpoint;
      s2_clip     <= s1_clip;
    end
  end

  // Stage 3: sum, round half up, clamp to the 32-bit signed range.
  logic signed [AccW-1:0]        acc;
  logic signed [AccW-1:0]        biased;
  logic signed [AccW-FracW-1:0]  rounded;
  logic                          over_hi, over_lo;
  logic signed [DriveW-1:0]      drive_next;

  always_comb begin
    acc = $signed({{(AccW-ProdPW){s2_prod_p[ProdPW-1]}}, s2_prod_p})
        + $signed({{(AccW-ProdIW){s2_prod_i[ProdIW-1]}}, s2_prod_i})
        + $signed({{(AccW-ProdDW){s2_prod_d[ProdDW-1]}}, s2_prod_d});
    biased  = acc + $signed({{(AccW-FracW){1'b0}}, 1'b1, {(FracW-1){1'b0}}});
    rounded = biased[AccW-1:FracW];
    over_hi = !rounded[AccW-FracW-1] && (|rounded[AccW-FracW-2:DriveW-1]);
    over_lo = rounded[AccW-FracW-1] && !(&rounded[AccW-FracW-2:DriveW-1]);
    if (over_hi) begin
      drive_next = {1'b0, {(DriveW-1){1'b1}}};
    end else if (over_lo) begin
      drive_next = {1'b1, {(DriveW-1){1'b0}}};
    end else begin
      drive_next = rounded[DriveW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive           <= drive_next;
      setpoint_used   <= s2_setpoint;
      integ_saturated <= s2_clip;
    end
  end

endmodule
